### sv/cpt_pkg.sv
// Shared constants for the closest-point-on-triangle pipeline.
// No dependencies; compile first.
`default_nettype none

package cpt_pkg;

  // Default coordinate width, signed fixed point (Q15.16 at 32 bits).
  localparam int COORD_WIDTH_DEF = 32;

  // Width of one multiplier slice in the wide multipliers.
  localparam int MUL_CHUNK = 34;

endpackage

`default_nettype wire

### sv/cpt_if.sv
// Valid/ready channel interfaces for the query and result streams.
// Depends on cpt_pkg for the default coordinate width.
`default_nettype none

interface cpt_req_if
  import cpt_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] query_x;
  logic signed [W-1:0] query_y;
  logic signed [W-1:0] query_z;
  logic signed [W-1:0] vertex_a_x;
  logic signed [W-1:0] vertex_a_y;
  logic signed [W-1:0] vertex_a_z;
  logic signed [W-1:0] vertex_b_x;
  logic signed [W-1:0] vertex_b_y;
  logic signed [W-1:0] vertex_b_z;
  logic signed [W-1:0] vertex_c_x;
  logic signed [W-1:0] vertex_c_y;
  logic signed [W-1:0] vertex_c_z;

  modport source (
    output valid, query_x, query_y, query_z,
    output vertex_a_x, vertex_a_y, vertex_a_z,
    output vertex_b_x, vertex_b_y, vertex_b_z,
    output vertex_c_x, vertex_c_y, vertex_c_z,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_z,
    input  vertex_a_x, vertex_a_y, vertex_a_z,
    input  vertex_b_x, vertex_b_y, vertex_b_z,
    input  vertex_c_x, vertex_c_y, vertex_c_z,
    output ready
  );
endinterface

interface cpt_rsp_if
  import cpt_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] closest_x;
  logic signed [W-1:0] closest_y;
  logic signed [W-1:0] closest_z;
  logic                degenerate;

  modport source (
    output valid, closest_x, closest_y, closest_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, closest_x, closest_y, closest_z, degenerate,
    output ready
  );
endinterface

`default_nettype wire

### sv/closest_point_on_triangle.sv
// Closest point on a triangle: top level, a fully pipelined Voronoi-region datapath.
// Depends on cpt_pkg, cpt_if (cpt_req_if, cpt_rsp_if) and cpt_mul.
`default_nettype none

// The block takes one query per clock while the pipe advances: a point Q and
// triangle vertices A, B, C, all signed fixed point of COORD_WIDTH bits (the
// fraction position does not matter, every ratio cancels it). It returns the
// point of the triangle closest to Q. Region tests run on exact integer dot
// products and cross terms, so the vertex / edge / face decision carries no
// rounding; the point on an edge or the face is formed with one divide per
// coordinate, rounded to nearest with ties away from zero, then added to the
// base vertex and saturated. A zero-length edge returns the edge start point. A
// zero-area triangle that reaches the face test returns A with degenerate set.
// Throughput is one transaction per cycle when not stalled. The restoring
// divider resolves one quotient bit per stage over COORD_WIDTH+1 stages, after
// three 3-stage multiplier rounds. The whole pipe advances together whenever the
// output register is empty or being drained; a stalled result holds in place and
// nothing behind it moves. No query is taken during reset.
module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cpt_req_if.sink    req,
  cpt_rsp_if.source  rsp
);

  localparam int W    = COORD_WIDTH;
  localparam int D    = W + 1;           // coordinate difference
  localparam int K    = 2 * D + 2;       // dot product
  localparam int KE   = K + 1;           // difference of two dot products
  localparam int WW   = 2 * K + 1;       // barycentric cross term
  localparam int DENW = WW + 2;          // face denominator
  localparam int NW   = D + WW + 1;      // division numerator
  localparam int XW   = NW + 3;          // divider working width
  localparam int QB   = W + 1;           // quotient bits kept before clamping
  localparam int NST  = 18 + QB;         // register stages, input to output
  localparam int GDN  = 8;               // geometry delay, stage 2 to stage 9
  localparam int SCN  = 4;               // scalar delay, stage 6 to stage 9
  localparam int MDN  = 4;               // selection delay, stage 10 to stage 13

  localparam logic signed [W+2:0] SMAX = (W+3)'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [W+2:0] SMIN = -SMAX - (W+3)'(1);

  typedef struct packed {
    logic [8:0][W-1:0] vtx;      // a, b, c
    logic [2:0][D-1:0] eu;
    logic [2:0][D-1:0] ev;
    logic [2:0][D-1:0] ebc;
  } geo_t;

  typedef struct packed {
    logic          k1le, k1ge, k2le, k2ge;
    logic          k3le, k3ge, k6le, k6ge;
    logic          t1le, t1ge, t2le, t2ge;
    logic [KE-1:0] dab;
    logic [KE-1:0] dac;
    logic [KE-1:0] t1;
    logic [K+1:0]  dbc;
    logic [K-1:0]  k1;
    logic [K-1:0]  k2;
  } sc_t;

  typedef struct packed {
    logic [2:0][W-1:0] base;
    logic [DENW-1:0]   den;
    logic              direct;
    logic              face;
  } sel_t;

  typedef struct packed {
    logic [2:0][W-1:0] base;
    logic              direct;
    logic              deg;
  } nm_t;

  typedef struct packed {
    logic [2:0][W-1:0] base;
    logic              direct;
    logic              deg;
    logic [2:0]        nsg;
    logic [2:0]        ovf;
  } dv_t;

  // Global advance: the pipe moves when the result register can take a value.
  logic             en;
  logic [NST-1:0]   vld;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en && !rst;
  assign rsp.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  // ---------------- stage 1: differences ----------------
  logic signed [D-1:0] qi [3];
  logic signed [D-1:0] ai [3];
  logic signed [D-1:0] bi [3];
  logic signed [D-1:0] ci [3];

  assign qi[0] = D'(req.query_x);
  assign qi[1] = D'(req.query_y);
  assign qi[2] = D'(req.query_z);
  assign ai[0] = D'(req.vertex_a_x);
  assign ai[1] = D'(req.vertex_a_y);
  assign ai[2] = D'(req.vertex_a_z);
  assign bi[0] = D'(req.vertex_b_x);
  assign bi[1] = D'(req.vertex_b_y);
  assign bi[2] = D'(req.vertex_b_z);
  assign ci[0] = D'(req.vertex_c_x);
  assign ci[1] = D'(req.vertex_c_y);
  assign ci[2] = D'(req.vertex_c_z);

  logic signed [D-1:0] eu1 [3];
  logic signed [D-1:0] ev1 [3];
  logic signed [D-1:0] ebc1 [3];
  logic signed [D-1:0] ra1 [3];
  logic signed [D-1:0] rb1 [3];
  logic signed [D-1:0] rc1 [3];
  logic [8:0][W-1:0]   vtx1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        eu1[k]  <= bi[k] - ai[k];
        ev1[k]  <= ci[k] - ai[k];
        ebc1[k] <= ci[k] - bi[k];
        ra1[k]  <= qi[k] - ai[k];
        rb1[k]  <= qi[k] - bi[k];
        rc1[k]  <= qi[k] - ci[k];
      end
      vtx1 <= {req.vertex_c_z, req.vertex_c_y, req.vertex_c_x,
               req.vertex_b_z, req.vertex_b_y, req.vertex_b_x,
               req.vertex_a_z, req.vertex_a_y, req.vertex_a_x};
    end
  end

  // Hold geometry alongside the arithmetic until the selection stage.
  geo_t gd [GDN];

  always_ff @(posedge clk) begin
    if (en) begin
      gd[0].vtx <= vtx1;
      for (int k = 0; k < 3; k++) begin
        gd[0].eu[k]  <= eu1[k];
        gd[0].ev[k]  <= ev1[k];
        gd[0].ebc[k] <= ebc1[k];
      end
      for (int j = 1; j < GDN; j++) begin
        gd[j] <= gd[j-1];
      end
    end
  end

  // ---------------- stages 2-4: dot product terms ----------------
  // Pairs: eu.ra, ev.ra, eu.rb, ev.rb, eu.rc, ev.rc -> k1..k6
  logic signed [D-1:0]     ma1 [6][3];
  logic signed [D-1:0]     mb1 [6][3];
  logic signed [2*D-1:0]   prod1 [6][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma1[0][k] = eu1[k]; mb1[0][k] = ra1[k];
      ma1[1][k] = ev1[k]; mb1[1][k] = ra1[k];
      ma1[2][k] = eu1[k]; mb1[2][k] = rb1[k];
      ma1[3][k] = ev1[k]; mb1[3][k] = rb1[k];
      ma1[4][k] = eu1[k]; mb1[4][k] = rc1[k];
      ma1[5][k] = ev1[k]; mb1[5][k] = rc1[k];
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_axis
      cpt_mul #(.WA(D), .WB(D)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (ma1[g][k]),
        .b   (mb1[g][k]),
        .p   (prod1[g][k])
      );
    end
  end

  // ---------------- stage 5: dot product sums ----------------
  logic signed [K-1:0] kk [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 6; g++) begin
        kk[g] <= K'(prod1[g][0]) + K'(prod1[g][1]) + K'(prod1[g][2]);
      end
    end
  end

  // ---------------- stage 6: sign tests and edge terms ----------------
  logic signed [KE-1:0] t1c;
  logic signed [KE-1:0] t2c;
  sc_t                  sc_next;
  sc_t                  scd [SCN];

  always_comb begin
    t1c = KE'(kk[3]) - KE'(kk[2]);
    t2c = KE'(kk[4]) - KE'(kk[5]);
    sc_next.k1le = kk[0][K-1] || (kk[0] == '0);
    sc_next.k1ge = !kk[0][K-1];
    sc_next.k2le = kk[1][K-1] || (kk[1] == '0);
    sc_next.k2ge = !kk[1][K-1];
    sc_next.k3le = kk[2][K-1] || (kk[2] == '0);
    sc_next.k3ge = !kk[2][K-1];
    sc_next.k6le = kk[5][K-1] || (kk[5] == '0);
    sc_next.k6ge = !kk[5][K-1];
    sc_next.t1le = t1c[KE-1] || (t1c == '0);
    sc_next.t1ge = !t1c[KE-1];
    sc_next.t2le = t2c[KE-1] || (t2c == '0);
    sc_next.t2ge = !t2c[KE-1];
    sc_next.dab  = KE'(kk[0]) - KE'(kk[2]);
    sc_next.dac  = KE'(kk[1]) - KE'(kk[5]);
    sc_next.t1   = t1c;
    sc_next.dbc  = (K+2)'(kk[3]) - (K+2)'(kk[2]) + (K+2)'(kk[4]) - (K+2)'(kk[5]);
    sc_next.k1   = kk[0];
    sc_next.k2   = kk[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scd[0] <= sc_next;
      for (int j = 1; j < SCN; j++) begin
        scd[j] <= scd[j-1];
      end
    end
  end

  // ---------------- stages 6-8: cross products of dot terms ----------------
  // k1*k4, k3*k2, k5*k2, k1*k6, k3*k6, k5*k4
  logic signed [K-1:0]   ma2 [6];
  logic signed [K-1:0]   mb2 [6];
  logic signed [2*K-1:0] prod2 [6];

  always_comb begin
    ma2[0] = kk[0]; mb2[0] = kk[3];
    ma2[1] = kk[2]; mb2[1] = kk[1];
    ma2[2] = kk[4]; mb2[2] = kk[1];
    ma2[3] = kk[0]; mb2[3] = kk[5];
    ma2[4] = kk[2]; mb2[4] = kk[5];
    ma2[5] = kk[4]; mb2[5] = kk[3];
  end

  for (genvar g = 0; g < 6; g++) begin : g_cross
    cpt_mul #(.WA(K), .WB(K)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma2[g]),
      .b   (mb2[g]),
      .p   (prod2[g])
    );
  end

  // ---------------- stage 9: barycentric terms ----------------
  logic signed [WW-1:0] wa;
  logic signed [WW-1:0] wb;
  logic signed [WW-1:0] wc;

  always_ff @(posedge clk) begin
    if (en) begin
      wc <= WW'(prod2[0]) - WW'(prod2[1]);
      wb <= WW'(prod2[2]) - WW'(prod2[3]);
      wa <= WW'(prod2[4]) - WW'(prod2[5]);
    end
  end

  // ---------------- stage 10: region select ----------------
  // Tested in order: vertex A, vertex B, edge AB, vertex C, edge AC, edge BC, face.
  geo_t                g9;
  sc_t                 f9;
  logic                le_wa, le_wb, le_wc;
  sel_t                sel_next;
  logic signed [D-1:0] mx_next [3];
  logic signed [D-1:0] mx2_next [3];
  logic signed [WW-1:0] my_next;
  logic signed [WW-1:0] my2_next;

  always_comb begin
    g9    = gd[GDN-1];
    f9    = scd[SCN-1];
    le_wa = wa[WW-1] || (wa == '0);
    le_wb = wb[WW-1] || (wb == '0);
    le_wc = wc[WW-1] || (wc == '0);

    sel_next.base   = {g9.vtx[2], g9.vtx[1], g9.vtx[0]};
    sel_next.den    = '0;
    sel_next.direct = 1'b0;
    sel_next.face   = 1'b0;
    my_next         = '0;
    my2_next        = '0;
    for (int k = 0; k < 3; k++) begin
      mx_next[k]  = '0;
      mx2_next[k] = '0;
    end

    if (f9.k1le && f9.k2le) begin
      sel_next.direct = 1'b1;
    end else if (f9.k3ge && f9.t1le) begin
      sel_next.base   = {g9.vtx[5], g9.vtx[4], g9.vtx[3]};
      sel_next.direct = 1'b1;
    end else if (le_wc && f9.k1ge && f9.k3le) begin
      for (int k = 0; k < 3; k++) begin
        mx_next[k] = $signed(g9.eu[k]);
      end
      my_next      = WW'($signed(f9.k1));
      sel_next.den = DENW'($signed(f9.dab));
    end else if (f9.k6ge && f9.t2le) begin
      sel_next.base   = {g9.vtx[8], g9.vtx[7], g9.vtx[6]};
      sel_next.direct = 1'b1;
    end else if (le_wb && f9.k2ge && f9.k6le) begin
      for (int k = 0; k < 3; k++) begin
        mx_next[k] = $signed(g9.ev[k]);
      end
      my_next      = WW'($signed(f9.k2));
      sel_next.den = DENW'($signed(f9.dac));
    end else if (le_wa && f9.t1ge && f9.t2ge) begin
      sel_next.base = {g9.vtx[5], g9.vtx[4], g9.vtx[3]};
      for (int k = 0; k < 3; k++) begin
        mx_next[k] = $signed(g9.ebc[k]);
      end
      my_next      = WW'($signed(f9.t1));
      sel_next.den = DENW'($signed(f9.dbc));
    end else begin
      for (int k = 0; k < 3; k++) begin
        mx_next[k]  = $signed(g9.eu[k]);
        mx2_next[k] = $signed(g9.ev[k]);
      end
      my_next       = wb;
      my2_next      = wc;
      sel_next.den  = DENW'(wa) + DENW'(wb) + DENW'(wc);
      sel_next.face = 1'b1;
    end
  end

  logic signed [D-1:0]  mx [3];
  logic signed [D-1:0]  mx2 [3];
  logic signed [WW-1:0] my;
  logic signed [WW-1:0] my2;
  sel_t                 md [MDN];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mx[k]  <= mx_next[k];
        mx2[k] <= mx2_next[k];
      end
      my    <= my_next;
      my2   <= my2_next;
      md[0] <= sel_next;
      for (int j = 1; j < MDN; j++) begin
        md[j] <= md[j-1];
      end
    end
  end

  // ---------------- stages 11-13: numerator products ----------------
  logic signed [D+WW-1:0] pna [3];
  logic signed [D+WW-1:0] pnb [3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.WA(D), .WB(WW)) u_mul_a (
      .clk (clk),
      .en  (en),
      .a   (mx[k]),
      .b   (my),
      .p   (pna[k])
    );
    cpt_mul #(.WA(D), .WB(WW)) u_mul_b (
      .clk (clk),
      .en  (en),
      .a   (mx2[k]),
      .b   (my2),
      .p   (pnb[k])
    );
  end

  // ---------------- stage 14: numerator sum, zero denominator ----------------
  logic signed [NW-1:0]   num [3];
  logic signed [DENW-1:0] den14;
  nm_t                    nm14;
  sel_t                   s13;
  logic                   dz13;

  assign s13  = md[MDN-1];
  assign dz13 = (s13.den == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= NW'(pna[k]) + NW'(pnb[k]);
      end
      den14       <= $signed(s13.den);
      nm14.base   <= s13.base;
      nm14.direct <= s13.direct || dz13;
      nm14.deg    <= s13.face && dz13;
    end
  end

  // ---------------- stage 15: magnitudes and quotient sign ----------------
  logic [NW-1:0]   an [3];
  logic [DENW-1:0] ad;
  logic [2:0]      nsg15;
  nm_t             nm15;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        an[k]    <= $unsigned(num[k][NW-1] ? -num[k] : num[k]);
        nsg15[k] <= num[k][NW-1] ^ den14[DENW-1];
      end
      ad   <= $unsigned(den14[DENW-1] ? -den14 : den14);
      nm15 <= nm14;
    end
  end

  // ---------------- stage 16: rounding offset ----------------
  // round(n/d) = floor((2|n| + |d|) / (2|d|)), ties away from zero
  logic [XW-1:0] n2 [3];
  logic [XW-1:0] d2;
  logic [2:0]    nsg16;
  nm_t           nm16;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n2[k] <= (XW'(an[k]) << 1) + XW'(ad);
      end
      d2    <= XW'(ad) << 1;
      nsg16 <= nsg15;
      nm16  <= nm15;
    end
  end

  // ---------------- stage 17: overflow check ----------------
  // A quotient of 2^QB or more saturates the result whatever the base.
  // ---------------- stages 18..17+QB: restoring divide, one bit each ----------------
  logic [XW-1:0] rem [QB+1][3];
  logic [QB-1:0] qt  [QB+1][3];
  logic [XW-1:0] dd  [QB+1];
  dv_t           dv  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k]     <= n2[k];
        qt[0][k]      <= '0;
        dv[0].ovf[k]  <= (n2[k] >= (d2 << QB));
      end
      dd[0]        <= d2;
      dv[0].base   <= nm16.base;
      dv[0].direct <= nm16.direct;
      dv[0].deg    <= nm16.deg;
      dv[0].nsg    <= nsg16;

      for (int j = 0; j < QB; j++) begin
        for (int k = 0; k < 3; k++) begin
          if (rem[j][k] >= (dd[j] << (QB - 1 - j))) begin
            rem[j+1][k] <= rem[j][k] - (dd[j] << (QB - 1 - j));
            qt[j+1][k]  <= qt[j][k] | (QB'(1) << (QB - 1 - j));
          end else begin
            rem[j+1][k] <= rem[j][k];
            qt[j+1][k]  <= qt[j][k];
          end
        end
        dd[j+1] <= dd[j];
        dv[j+1] <= dv[j];
      end
    end
  end

  // ---------------- final stage: add base, saturate, output register ----------------
  dv_t              dvf;
  logic [W+1:0]     qm [3];
  logic signed [W+2:0] sv [3];
  logic [W-1:0]     res [3];

  always_comb begin
    dvf = dv[QB];
    for (int k = 0; k < 3; k++) begin
      qm[k] = dvf.ovf[k] ? ((W+2)'(1) << QB) : {1'b0, qt[QB][k]};
      sv[k] = (W+3)'($signed(dvf.base[k]))
            + (dvf.nsg[k] ? -$signed({1'b0, qm[k]}) : $signed({1'b0, qm[k]}));
      if (dvf.direct) begin
        res[k] = dvf.base[k];
      end else if (sv[k] > SMAX) begin
        res[k] = SMAX[W-1:0];
      end else if (sv[k] < SMIN) begin
        res[k] = SMIN[W-1:0];
      end else begin
        res[k] = sv[k][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.closest_x  <= $signed(res[0]);
      rsp.closest_y  <= $signed(res[1]);
      rsp.closest_z  <= $signed(res[2]);
      rsp.degenerate <= dvf.deg;
    end
  end

endmodule

`default_nettype wire

### sv/cpt_mul.sv
// Pipelined signed wide multiplier, three register stages, sliced partial products.
// Depends on cpt_pkg (MUL_CHUNK).
`default_nettype none

module cpt_mul
  import cpt_pkg::*;
#(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int SW = (NA + NB) * MUL_CHUNK;

  logic [NA*MUL_CHUNK-1:0]   ma;
  logic [NB*MUL_CHUNK-1:0]   mb;
  logic                      neg1;
  logic                      neg2;
  logic [2*MUL_CHUNK-1:0]    pp [NA][NB];
  logic [SW-1:0]             sum;
  logic [SW-1:0]             sum_sgn;

  // Magnitudes first, then slice products, then shifted sum with sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= (NA*MUL_CHUNK)'($unsigned(a[WA-1] ? -a : a));
      mb   <= (NB*MUL_CHUNK)'($unsigned(b[WB-1] ? -b : b));
      neg1 <= a[WA-1] ^ b[WB-1];
      neg2 <= neg1;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*MUL_CHUNK +: MUL_CHUNK] * mb[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
      p <= $signed(sum_sgn[WA+WB-1:0]);
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp[i][j]) << ((i + j) * MUL_CHUNK));
      end
    end
    sum_sgn = neg2 ? (~sum + 1'b1) : sum;
  end

endmodule

`default_nettype wire

### tb/tb_closest_point_on_triangle.sv
// Self-checking testbench for closest_point_on_triangle: directed table, then random queries.
// Depends on cpt_pkg and cpt_if (cpt_req_if, cpt_rsp_if) and the block itself.
`default_nettype none

module tb_closest_point_on_triangle;
  import cpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1630;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  // Wide enough for every product of the predictor without overflow.
  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   degenerate;
  } point_res_t;

  // Coordinates ordered Q, A, B, C; x, y, z within each.
  typedef struct {
    coord_t     c[12];
    logic       typed;
    point_res_t known;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpt_req_if #(.W(CW)) req_ch ();
  cpt_rsp_if #(.W(CW)) rsp_ch ();

  closest_point_on_triangle #(.COORD_WIDTH(CW)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  query_t     table_q[$];
  query_t     offered_q[$];
  point_res_t closest_q[$];
  int         failures = 0;
  int         req_count = 0;
  int         rsp_count = 0;
  int         quiet_cycles = 0;
  logic       burst_mode = 1'b0;

  // Round n/d to nearest, ties away from zero; d must be nonzero.
  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(wide_t v);
    wide_t hi, lo;
    hi = '0;
    hi[CW-2:0] = '1;
    lo = -hi - 1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  function automatic point_res_t make_point(wide_t px, wide_t py, wide_t pz, logic deg);
    point_res_t r;
    r.x = clamp_coord(px);
    r.y = clamp_coord(py);
    r.z = clamp_coord(pz);
    r.degenerate = deg;
    return r;
  endfunction

  function automatic point_res_t edge_point(wide_t bx, wide_t by, wide_t bz, wide_t dx,
                                            wide_t dy, wide_t dz, wide_t num, wide_t den);
    if (den == 0) return make_point(bx, by, bz, 1'b0);
    return make_point(bx + div_round(dx * num, den), by + div_round(dy * num, den),
                      bz + div_round(dz * num, den), 1'b0);
  endfunction

  // Voronoi-region walk: vertex A, vertex B, edge AB, vertex C, edge AC, edge BC, face.
  function automatic point_res_t predict_closest(query_t it);
    wide_t q[3], a[3], b[3], c[3], ab[3], ac[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den;
    for (int k = 0; k < 3; k++) begin
      q[k] = it.c[k];
      a[k] = it.c[3 + k];
      b[k] = it.c[6 + k];
      c[k] = it.c[9 + k];
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
    end
    d1 = ab[0] * (q[0] - a[0]) + ab[1] * (q[1] - a[1]) + ab[2] * (q[2] - a[2]);
    d2 = ac[0] * (q[0] - a[0]) + ac[1] * (q[1] - a[1]) + ac[2] * (q[2] - a[2]);
    if (d1 <= 0 && d2 <= 0) return make_point(a[0], a[1], a[2], 1'b0);
    d3 = ab[0] * (q[0] - b[0]) + ab[1] * (q[1] - b[1]) + ab[2] * (q[2] - b[2]);
    d4 = ac[0] * (q[0] - b[0]) + ac[1] * (q[1] - b[1]) + ac[2] * (q[2] - b[2]);
    if (d3 >= 0 && d4 - d3 <= 0) return make_point(b[0], b[1], b[2], 1'b0);
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0)
      return edge_point(a[0], a[1], a[2], ab[0], ab[1], ab[2], d1, d1 - d3);
    d5 = ab[0] * (q[0] - c[0]) + ab[1] * (q[1] - c[1]) + ab[2] * (q[2] - c[2]);
    d6 = ac[0] * (q[0] - c[0]) + ac[1] * (q[1] - c[1]) + ac[2] * (q[2] - c[2]);
    if (d6 >= 0 && d5 - d6 <= 0) return make_point(c[0], c[1], c[2], 1'b0);
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0)
      return edge_point(a[0], a[1], a[2], ac[0], ac[1], ac[2], d2, d2 - d6);
    va = d3 * d6 - d5 * d4;
    if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
      return edge_point(b[0], b[1], b[2], c[0] - b[0], c[1] - b[1], c[2] - b[2],
                        d4 - d3, (d4 - d3) + (d5 - d6));
    den = va + vb + vc;
    if (den == 0) return make_point(a[0], a[1], a[2], 1'b1);
    return make_point(a[0] + div_round(ab[0] * vb + ac[0] * vc, den),
                      a[1] + div_round(ab[1] * vb + ac[1] * vc, den),
                      a[2] + div_round(ab[2] * vb + ac[2] * vc, den), 1'b0);
  endfunction

  // Append one row to the directed table; typed rows carry a hand-read answer.
  task automatic add_row(coord_t qx, coord_t qy, coord_t qz, coord_t ax, coord_t ay,
                         coord_t az, coord_t bx, coord_t by, coord_t bz, coord_t cx,
                         coord_t cy, coord_t cz, logic typed, point_res_t known);
    query_t it;
    it.c = '{qx, qy, qz, ax, ay, az, bx, by, bz, cx, cy, cz};
    it.typed = typed;
    it.known = known;
    table_q.insert(table_q.size(), it);
  endtask

  function automatic coord_t small_coord();
    return coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
  endfunction

  // Mostly small well-shaped triangles; also full-range noise, collinear and repeated vertices.
  function automatic query_t random_query();
    query_t it;
    int kind, m;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) it.c[k] = (kind == 5) ? coord_t'($urandom) : small_coord();
    if (kind == 6) begin
      // collinear: C = A + m*(B - A)
      m = int'($urandom_range(0, 6)) - 3;
      for (int k = 0; k < 3; k++) begin
        it.c[3 + k] = it.c[3 + k] >>> 2;
        it.c[6 + k] = it.c[3 + k] + (small_coord() >>> 3);
        it.c[9 + k] = it.c[3 + k] + m * (it.c[6 + k] - it.c[3 + k]);
      end
    end else if (kind == 7) begin
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 1)) it.c[6 + k] = it.c[3 + k];
        else it.c[9 + k] = it.c[6 + k];
      end
    end else if (kind == 8) begin
      // flat in z: the query and all three vertices share one z plane
      for (int k = 0; k < 4; k++) it.c[3 * k + 2] = it.c[5];
    end else if (kind == 9) begin
      // large magnitudes push the edge and face sums into saturation
      for (int k = 0; k < 12; k++) it.c[k] = coord_t'($urandom) >>> $urandom_range(0, 2);
    end
    it.typed = 1'b0;
    it.known = '{default: '0};
    return it;
  endfunction

  task automatic check_field(string name, logic [CW-1:0] exp_v, logic [CW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      failures++;
    end
  endtask

  // Record each accepted query with its expected closest point.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      query_t it;
      it = offered_q.pop_front();
      closest_q.insert(closest_q.size(), it.typed ? it.known : predict_closest(it));
      req_count <= req_count + 1;
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      point_res_t exp_r;
      if (closest_q.size() == 0) begin
        $error("unexpected result: x=%0d y=%0d z=%0d", rsp_ch.closest_x, rsp_ch.closest_y,
               rsp_ch.closest_z);
        failures++;
      end else begin
        exp_r = closest_q.pop_front();
        check_field("closest_x", exp_r.x, rsp_ch.closest_x);
        check_field("closest_y", exp_r.y, rsp_ch.closest_y);
        check_field("closest_z", exp_r.z, rsp_ch.closest_z);
        check_field("degenerate", CW'(exp_r.degenerate), CW'(rsp_ch.degenerate));
      end
      rsp_count <= rsp_count + 1;
    end
  end

  // Watchdog: too many cycles with no transaction on either side ends the run.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result sink: draw a stall per result, none during burst stretches.
  initial begin
    int gap, seen;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      seen = rsp_count;
      do @(negedge clk); while (rsp_count == seen);
    end
  end

  // Present one query, hold it until accepted; valid drops only if a gap follows.
  task automatic send_query(query_t it);
    int gap, seen;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {req_ch.query_x, req_ch.query_y, req_ch.query_z} = {it.c[0], it.c[1], it.c[2]};
    {req_ch.vertex_a_x, req_ch.vertex_a_y, req_ch.vertex_a_z} = {it.c[3], it.c[4], it.c[5]};
    {req_ch.vertex_b_x, req_ch.vertex_b_y, req_ch.vertex_b_z} = {it.c[6], it.c[7], it.c[8]};
    {req_ch.vertex_c_x, req_ch.vertex_c_y, req_ch.vertex_c_z} = {it.c[9], it.c[10], it.c[11]};
    offered_q.insert(offered_q.size(), it);
    req_ch.valid = 1'b1;
    seen = req_count;
    do @(negedge clk); while (req_count == seen);
  endtask

  initial begin
    coord_t     cmax, cmin, one;
    point_res_t r;
    int         wait_cycles;
    cmax = '0;
    cmax[CW-2:0] = '1;
    cmin = ~cmax;
    one = coord_t'(1 << 16);
    req_ch.valid = 1'b0;
    {req_ch.query_x, req_ch.query_y, req_ch.query_z} = '0;
    {req_ch.vertex_a_x, req_ch.vertex_a_y, req_ch.vertex_a_z} = '0;
    {req_ch.vertex_b_x, req_ch.vertex_b_y, req_ch.vertex_b_z} = '0;
    {req_ch.vertex_c_x, req_ch.vertex_c_y, req_ch.vertex_c_z} = '0;

    // Directed table. Typed rows: query behind a vertex, or on a vertex, gives that vertex.
    r = '{x: '0, y: '0, z: '0, degenerate: 1'b0};
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, r);
    r = '{x: '0, y: '0, z: '0, degenerate: 1'b0};
    add_row(-one, -one, 0, 0, 0, 0, one, 0, 0, 0, one, 0, 1'b1, r);
    r = '{x: one, y: '0, z: '0, degenerate: 1'b0};
    add_row(3 * one, -one, 0, 0, 0, 0, one, 0, 0, 0, one, 0, 1'b1, r);
    r = '{x: '0, y: one, z: '0, degenerate: 1'b0};
    add_row(-one, 3 * one, 0, 0, 0, 0, one, 0, 0, 0, one, 0, 1'b1, r);
    r = '{x: cmax, y: cmax, z: cmax, degenerate: 1'b0};
    add_row(cmax, cmax, cmax, cmax, cmax, cmax, cmin, cmin, cmin, cmin, cmax, cmin, 1'b1, r);
    r = '{x: cmin, y: cmin, z: cmin, degenerate: 1'b0};
    add_row(cmin, cmin, cmin, cmin, cmin, cmin, cmax, cmax, cmax, cmax, cmin, cmax, 1'b1, r);
    // Edge regions, face interior, rounding ties, zero-length edges, zero-area face.
    add_row(one, -one, 0, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0, 1'b0, r);
    add_row(-one, one, 0, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0, 1'b0, r);
    add_row(2 * one, 2 * one, 0, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0, 1'b0, r);
    add_row(one / 2, one / 2, 5 * one, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0, 1'b0, r);
    add_row(1, 1, 7, 0, 0, 0, 3, 0, 0, 0, 3, 0, 1'b0, r);
    add_row(1, 0, 0, 0, 0, 0, 2, 1, 0, 0, 0, 0, 1'b0, r);
    add_row(one, one, 0, 0, 0, 0, 0, 0, 0, one, 0, 0, 1'b0, r);
    add_row(one, one, 0, 0, 0, 0, one, 0, 0, one, 0, 0, 1'b0, r);
    add_row(one, one, 0, 0, 0, 0, 2 * one, 0, 0, one, 0, 0, 1'b0, r);
    add_row(one, -one, 0, 0, 0, 0, 4 * one, 0, 0, 2 * one, 0, 0, 1'b0, r);
    add_row(3, 1, 0, 0, 0, 0, 2, 0, 0, 4, 0, 0, 1'b0, r);
    add_row(0, 0, 0, cmin, cmin, cmin, cmax, cmin, cmin, cmin, cmax, cmin, 1'b0, r);
    add_row(cmax, cmax, cmax, cmin, cmin, cmin, cmax, cmin, cmin, cmin, cmax, cmin, 1'b0, r);
    add_row(cmin, cmax, 0, cmax, cmin, cmax, cmin, cmax, cmin, cmax, cmax, cmin, 1'b0, r);
    add_row(-1, -1, -1, cmax, cmin, 0, cmin, cmax, 0, cmin, cmin, cmax, 1'b0, r);
    add_row(cmax, cmin, cmax, 1, -1, 1, -1, 1, -1, cmax, cmax, cmin, 1'b0, r);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (table_q[i]) send_query(table_q[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate stretches of random idling with stretches of back-to-back traffic.
      if (n % 200 == 0) burst_mode = (n % 400 == 200);
      if (n == RANDOM_ITEMS / 2) begin
        // Hold the sender until the pipe has fully drained.
        req_ch.valid = 1'b0;
        while (closest_q.size() != 0 || offered_q.size() != 0) @(negedge clk);
      end
      send_query(random_query());
    end
    req_ch.valid = 1'b0;
    burst_mode = 1'b0;

    // Wait for the pipeline to drain, then idle before the final check.
    wait_cycles = 0;
    while (closest_q.size() != 0 && wait_cycles < 50 * STALL_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (closest_q.size() != 0) begin
      $error("%0d expected results never arrived", closest_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/cpt_pkg.sv
sv/cpt_if.sv
sv/cpt_mul.sv
sv/closest_point_on_triangle.sv
tb/tb_closest_point_on_triangle.sv
